[rtl/hsvrgb_pkg.sv]
// ---------------------------------------------------------------------------
// hsvrgb_pkg
// Shared constants and types for the HSV to RGB565 converter pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package hsvrgb_pkg;

	// Field widths.
	localparam int HUE_W  = 16;
	localparam int CHAN_W = 8;
	localparam int H_W    = 11;   // scaled hue, 0..1530
	localparam int PIX_W  = 16;

	// Hue scaling: h = (hue * HUE_STEPS + HUE_ROUND) >> HUE_W.
	localparam logic [H_W-1:0]     HUE_STEPS = 11'd1530;
	localparam logic [HUE_W+H_W-1:0] HUE_ROUND = 27'd32768;

	// Hexcone segment boundaries.
	localparam logic [H_W-1:0] SEG1 = 11'd255;
	localparam logic [H_W-1:0] SEG2 = 11'd510;
	localparam logic [H_W-1:0] SEG3 = 11'd765;
	localparam logic [H_W-1:0] SEG4 = 11'd1020;
	localparam logic [H_W-1:0] SEG5 = 11'd1275;

	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

	// Per-stage load enables, driven by the pipeline control in the top level.
	typedef struct packed {
		logic ld_s1;
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} pipe_ctl_t;

endpackage

`default_nettype wire

[rtl/hsvrgb_hue.sv]
// ---------------------------------------------------------------------------
// hsvrgb_hue
// Stages one and two: hue rescaling to 0..1530 and the hexcone lookup.
// ---------------------------------------------------------------------------
`default_nettype none

module hsvrgb_hue
	import hsvrgb_pkg::*;
(
	input  wire logic              clk,
	input  wire pipe_ctl_t         ctl,
	input  wire logic [HUE_W-1:0]  hue,
	output logic      [CHAN_W-1:0] red_s2,
	output logic      [CHAN_W-1:0] green_s2,
	output logic      [CHAN_W-1:0] blue_s2
);

	logic [HUE_W+H_W-1:0] scaled;
	logic [H_W-1:0]       h_s1;
	logic [H_W-1:0]       diff;
	logic [CHAN_W-1:0]    r_d, g_d, b_d;

	// Rounded rescale; the sum stays below 2^27.
	assign scaled = HUE_W'(hue) * HUE_STEPS + HUE_ROUND;

	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			h_s1 <= scaled[HUE_W+H_W-1:HUE_W];
		end
	end

	// Walk the six segments; every falling or rising ramp fits in 8 bits.
	always_comb begin
		diff = '0;
		r_d  = '0;
		g_d  = '0;
		b_d  = '0;
		priority if (h_s1 < SEG1) begin
			r_d = CHAN_MAX;
			g_d = h_s1[CHAN_W-1:0];
		end else if (h_s1 < SEG2) begin
			diff = SEG2 - h_s1;
			r_d  = diff[CHAN_W-1:0];
			g_d  = CHAN_MAX;
		end else if (h_s1 < SEG3) begin
			diff = h_s1 - SEG2;
			g_d  = CHAN_MAX;
			b_d  = diff[CHAN_W-1:0];
		end else if (h_s1 < SEG4) begin
			diff = SEG4 - h_s1;
			g_d  = diff[CHAN_W-1:0];
			b_d  = CHAN_MAX;
		end else if (h_s1 < SEG5) begin
			diff = h_s1 - SEG4;
			r_d  = diff[CHAN_W-1:0];
			b_d  = CHAN_MAX;
		end else if (h_s1 < HUE_STEPS) begin
			diff = HUE_STEPS - h_s1;
			r_d  = CHAN_MAX;
			b_d  = diff[CHAN_W-1:0];
		end else begin
			// The top rounded hue wraps back to pure red.
			r_d = CHAN_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ld_s2) begin
			red_s2   <= r_d;
			green_s2 <= g_d;
			blue_s2  <= b_d;
		end
	end

endmodule

`default_nettype wire

[rtl/hsvrgb_shade.sv]
// ---------------------------------------------------------------------------
// hsvrgb_shade
// Stages three and four for one channel: saturation blend, then brightness.
// ---------------------------------------------------------------------------
`default_nettype none

module hsvrgb_shade
	import hsvrgb_pkg::*;
(
	input  wire logic              clk,
	input  wire pipe_ctl_t         ctl,
	input  wire logic [CHAN_W-1:0] chan_s2,
	input  wire logic [CHAN_W-1:0] sat_s2,
	input  wire logic [CHAN_W-1:0] val_s3,
	output logic      [CHAN_W-1:0] shaded_s4
);

	logic [CHAN_W:0]       sat_p1;
	logic [2*CHAN_W:0]     sat_prod;
	logic [CHAN_W:0]       blend;
	logic [CHAN_W-1:0]     t_s3;
	logic [CHAN_W:0]       val_p1;
	logic [2*CHAN_W:0]     val_prod;

	assign sat_p1   = {1'b0, sat_s2} + 1'b1;
	assign sat_prod = (2*CHAN_W+1)'(chan_s2) * (2*CHAN_W+1)'(sat_p1);
	// The blended value never exceeds 255.
	assign blend    = sat_prod[2*CHAN_W:CHAN_W] + {1'b0, ~sat_s2};

	always_ff @(posedge clk) begin
		if (ctl.ld_s3) begin
			t_s3 <= blend[CHAN_W-1:0];
		end
	end

	assign val_p1   = {1'b0, val_s3} + 1'b1;
	assign val_prod = (2*CHAN_W+1)'(t_s3) * (2*CHAN_W+1)'(val_p1);

	always_ff @(posedge clk) begin
		if (ctl.ld_s4) begin
			shaded_s4 <= val_prod[2*CHAN_W-1:CHAN_W];
		end
	end

endmodule

`default_nettype wire

[rtl/hsv_to_rgb565.sv]
// ---------------------------------------------------------------------------
// hsv_to_rgb565
// Four-stage pipelined HSV to RGB565 color converter.
// ---------------------------------------------------------------------------
// The converter takes one HSV pixel per cycle and returns its RGB565 color
// through the four register stages when the output side is ready. The
// hue is rescaled with rounding onto a 1530-step six-segment hexcone, each
// pure channel is blended toward white by saturation and scaled by
// brightness, and the top 5, 6 and 5 bits of red, green and blue are packed.
// In the pipeline the hue multiply, the hexcone lookup, the saturation
// multiply and the brightness multiply each own one register stage.
// Throughput is one transfer per cycle; when the output stalls, bubbles
// in the pipeline are squeezed out first, and input ready drops only once
// all four stages hold an item. No state survives an item, so reset only
// clears the stage valid bits.
// ---------------------------------------------------------------------------
`default_nettype none

module hsv_to_rgb565
	import hsvrgb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              hsv_valid,
	output logic                   hsv_ready,
	input  wire logic [HUE_W-1:0]  hue,
	input  wire logic [CHAN_W-1:0] saturation,
	input  wire logic [CHAN_W-1:0] brightness,
	output logic                   rgb_valid,
	input  wire logic              rgb_ready,
	output logic      [PIX_W-1:0]  rgb565
);

	pipe_ctl_t         ctl;
	logic              v_s1, v_s2, v_s3, v_s4;
	logic [CHAN_W-1:0] sat_s1, sat_s2;
	logic [CHAN_W-1:0] val_s1, val_s2, val_s3;
	logic [CHAN_W-1:0] red_s2, green_s2, blue_s2;
	logic [CHAN_W-1:0] red_s4, green_s4, blue_s4;

	// A stage loads when it is empty or its content moves on this cycle.
	always_comb begin
		ctl.ld_s4 = !v_s4 || rgb_ready;
		ctl.ld_s3 = !v_s3 || ctl.ld_s4;
		ctl.ld_s2 = !v_s2 || ctl.ld_s3;
		ctl.ld_s1 = !v_s1 || ctl.ld_s2;
	end

	assign hsv_ready = ctl.ld_s1;
	assign rgb_valid = v_s4;

	// Valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (ctl.ld_s1) v_s1 <= hsv_valid;
			if (ctl.ld_s2) v_s2 <= v_s1;
			if (ctl.ld_s3) v_s3 <= v_s2;
			if (ctl.ld_s4) v_s4 <= v_s3;
		end
	end

	// Saturation is consumed in stage three, brightness in stage four.
	always_ff @(posedge clk) begin
		if (ctl.ld_s1) begin
			sat_s1 <= saturation;
			val_s1 <= brightness;
		end
		if (ctl.ld_s2) begin
			sat_s2 <= sat_s1;
			val_s2 <= val_s1;
		end
		if (ctl.ld_s3) begin
			val_s3 <= val_s2;
		end
	end

	hsvrgb_hue u_hue (
		.clk      (clk),
		.ctl      (ctl),
		.hue      (hue),
		.red_s2   (red_s2),
		.green_s2 (green_s2),
		.blue_s2  (blue_s2)
	);

	hsvrgb_shade u_shade_red (
		.clk       (clk),
		.ctl       (ctl),
		.chan_s2   (red_s2),
		.sat_s2    (sat_s2),
		.val_s3    (val_s3),
		.shaded_s4 (red_s4)
	);

	hsvrgb_shade u_shade_green (
		.clk       (clk),
		.ctl       (ctl),
		.chan_s2   (green_s2),
		.sat_s2    (sat_s2),
		.val_s3    (val_s3),
		.shaded_s4 (green_s4)
	);

	hsvrgb_shade u_shade_blue (
		.clk       (clk),
		.ctl       (ctl),
		.chan_s2   (blue_s2),
		.sat_s2    (sat_s2),
		.val_s3    (val_s3),
		.shaded_s4 (blue_s4)
	);

	// Keep the top bits of each channel for the 5-6-5 packing.
	assign rgb565 = {red_s4[CHAN_W-1:3], green_s4[CHAN_W-1:2], blue_s4[CHAN_W-1:3]};

	// Input is refused only when every stage is full and the output stalls.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!hsv_ready |-> (v_s1 && v_s2 && v_s3 && v_s4 && !rgb_ready))
		else $error("input stalled while the pipeline has a bubble");

	// With the output held ready, an accepted transfer passes through every stage and shows on the output as valid.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && hsv_ready ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready)
		|=> rgb_valid)
		else $error("accepted transfer did not reach the output in time");

	// Zero saturation at full brightness gives white.
	a_white: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && hsv_ready && saturation == '0 && brightness == CHAN_MAX
		 ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready)
		|=> (rgb565 == {PIX_W{1'b1}}))
		else $error("gray at full brightness did not give white");

	// Zero brightness gives black whatever the hue.
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && hsv_ready && brightness == '0
		 ##1 rgb_ready ##1 rgb_ready ##1 rgb_ready)
		|=> (rgb565 == '0))
		else $error("zero brightness did not give black");

endmodule

`default_nettype wire
